### rtl/fsi_pkg.sv
// shared types and constants of the format sector id interleaver
`default_nettype none
package fsi_pkg;

   localparam int TRACK_WIDTH  = 8;
   localparam int SECTOR_WIDTH = 6;
   localparam int HEADS_WIDTH  = 2;
   localparam int SIZE_WIDTH   = 2;
   localparam int CSR_WIDTH    = 6;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SECTOR_WIDTH-1:0] SPT_SHORT = 6'd18;
   localparam logic [SECTOR_WIDTH-1:0] SPT_LONG  = 6'd21;
   localparam logic [SECTOR_WIDTH-1:0] SPT_RESET = 6'd18;
   localparam logic [HEADS_WIDTH-1:0]  HEADS_RESET = 2'd2;
   localparam logic [SIZE_WIDTH-1:0]   SIZE_CODE_512 = 2'd2;
   localparam logic [SIZE_WIDTH-1:0]   SIZE_CODE_NONE = 2'd0;

   localparam logic CSR_SECTORS_PER_TRACK = 1'b0;
   localparam logic CSR_HEAD_COUNT        = 1'b1;

   typedef struct packed {
      logic [TRACK_WIDTH-1:0] track;
      logic                   bad;
      logic                   spt_long;
      logic                   two_heads;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage
`default_nettype wire

### rtl/fsi_front.sv
// front end: configuration registers, track classification and command queue
`default_nettype none
module fsi_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  wire  [fsi_pkg::TRACK_WIDTH-1:0]      req_track_number,
   input  wire                                  csr_write_enable,
   input  wire                                  csr_index,
   input  wire  [fsi_pkg::CSR_WIDTH-1:0]        csr_write_data,
   output fsi_pkg::cmd_link_type                cmd_link,
   input  wire                                  cmd_take
);

   logic [fsi_pkg::SECTOR_WIDTH-1:0]    spt_ff;
   logic [fsi_pkg::HEADS_WIDTH-1:0]     heads_ff;
   fsi_pkg::cmd_type                    queue_ff [fsi_pkg::QUEUE_DEPTH];
   logic [fsi_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fsi_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fsi_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   fsi_pkg::cmd_type                    new_cmd;
   logic                                accept;
   logic                                store;
   logic                                take;

   always_comb begin
      new_cmd.track     = req_track_number;
      new_cmd.bad       = (spt_ff != fsi_pkg::SPT_SHORT) && (spt_ff != fsi_pkg::SPT_LONG);
      new_cmd.spt_long  = (spt_ff == fsi_pkg::SPT_LONG);
      new_cmd.two_heads = heads_ff[1];
   end

   assign req_full = (count_ff == fsi_pkg::QUEUE_CNT_WIDTH'(fsi_pkg::QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   // a good geometry with no heads gives no entries, so it is dropped here
   assign store    = accept && (new_cmd.bad || (heads_ff != '0));
   assign take     = cmd_take && (count_ff != '0);

   assign cmd_link.valid = (count_ff != '0);
   assign cmd_link.cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (store) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (store && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!store && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff    <= fsi_pkg::SPT_RESET;
         heads_ff  <= fsi_pkg::HEADS_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               fsi_pkg::CSR_SECTORS_PER_TRACK: begin
                  spt_ff <= csr_write_data;
               end
               fsi_pkg::CSR_HEAD_COUNT: begin
                  heads_ff <= csr_write_data[fsi_pkg::HEADS_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/fsi_back.sv
// back end: sector id sequencer and result register
`default_nettype none
module fsi_back (
   input  wire                                  clock,
   input  wire                                  reset,
   input  fsi_pkg::cmd_link_type                cmd_link,
   output logic                                 cmd_take,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output logic [fsi_pkg::TRACK_WIDTH-1:0]      rsp_id_track,
   output logic                                 rsp_id_head,
   output logic [fsi_pkg::SECTOR_WIDTH-1:0]     rsp_id_sector,
   output logic [fsi_pkg::SIZE_WIDTH-1:0]       rsp_id_size_code,
   output logic                                 rsp_last_entry,
   output logic                                 rsp_bad_geometry
);

   localparam int IdWidth = fsi_pkg::SECTOR_WIDTH + 1;

   fsi_pkg::cmd_type                  cmd_ff, cmd_in;
   logic                              busy_ff, busy_in;
   logic                              head_ff, head_in;
   logic [fsi_pkg::SECTOR_WIDTH-1:0]  sect_ff, sect_in;
   logic                              out_valid_ff, out_valid_in;
   logic [fsi_pkg::TRACK_WIDTH-1:0]   out_track_ff, out_track_in;
   logic                              out_head_ff, out_head_in;
   logic [fsi_pkg::SECTOR_WIDTH-1:0]  out_sector_ff, out_sector_in;
   logic [fsi_pkg::SIZE_WIDTH-1:0]    out_size_ff, out_size_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_bad_ff, out_bad_in;

   logic [fsi_pkg::SECTOR_WIDTH-1:0]  spt;
   logic [fsi_pkg::SECTOR_WIDTH-1:0]  half;
   logic [fsi_pkg::SECTOR_WIDTH-1:0]  split;
   logic [IdWidth-1:0]                id_base, id_head, id_trk;
   logic                              last;
   logic                              emit;

   always_comb begin
      spt   = cmd_ff.spt_long ? fsi_pkg::SPT_LONG : fsi_pkg::SPT_SHORT;
      half  = spt >> 1;
      split = half + {5'd0, spt[0]};
      id_base = IdWidth'(sect_ff >> 1) + IdWidth'(1);
      if (sect_ff[0]) begin
         id_base = id_base + IdWidth'(split);
      end
      id_head = id_base;
      if (head_ff) begin
         if (id_base <= IdWidth'(2)) begin
            id_head = id_base + IdWidth'(spt) - IdWidth'(2);
         end else begin
            id_head = id_base - IdWidth'(2);
         end
      end
      id_trk = id_head;
      if (cmd_ff.track[0]) begin
         if (id_head <= IdWidth'(half)) begin
            id_trk = id_head + IdWidth'(spt) - IdWidth'(half);
         end else begin
            id_trk = id_head - IdWidth'(half);
         end
      end
      last = (sect_ff == spt - 1'b1) && (head_ff || !cmd_ff.two_heads);
   end

   assign emit     = busy_ff && (!out_valid_ff || rsp_pop);
   assign cmd_take = !busy_ff && cmd_link.valid;

   always_comb begin
      cmd_in        = cmd_ff;
      busy_in       = busy_ff;
      head_in       = head_ff;
      sect_in       = sect_ff;
      out_valid_in  = out_valid_ff;
      out_track_in  = out_track_ff;
      out_head_in   = out_head_ff;
      out_sector_in = out_sector_ff;
      out_size_in   = out_size_ff;
      out_last_in   = out_last_ff;
      out_bad_in    = out_bad_ff;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (cmd_take) begin
         cmd_in  = cmd_link.cmd;
         busy_in = 1'b1;
         head_in = 1'b0;
         sect_in = '0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_track_in = cmd_ff.track;
         if (cmd_ff.bad) begin
            out_head_in   = 1'b0;
            out_sector_in = '0;
            out_size_in   = fsi_pkg::SIZE_CODE_NONE;
            out_last_in   = 1'b1;
            out_bad_in    = 1'b1;
            busy_in       = 1'b0;
         end else begin
            out_head_in   = head_ff;
            out_sector_in = id_trk[fsi_pkg::SECTOR_WIDTH-1:0];
            out_size_in   = fsi_pkg::SIZE_CODE_512;
            out_last_in   = last;
            out_bad_in    = 1'b0;
            if (last) begin
               busy_in = 1'b0;
            end else if (sect_ff == spt - 1'b1) begin
               sect_in = '0;
               head_in = 1'b1;
            end else begin
               sect_in = sect_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         head_ff      <= 1'b0;
         sect_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         head_ff      <= head_in;
         sect_ff      <= sect_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      out_track_ff  <= out_track_in;
      out_head_ff   <= out_head_in;
      out_sector_ff <= out_sector_in;
      out_size_ff   <= out_size_in;
      out_last_ff   <= out_last_in;
      out_bad_ff    <= out_bad_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_id_track     = out_track_ff;
   assign rsp_id_head      = out_head_ff;
   assign rsp_id_sector    = out_sector_ff;
   assign rsp_id_size_code = out_size_ff;
   assign rsp_last_entry   = out_last_ff;
   assign rsp_bad_geometry = out_bad_ff;

endmodule
`default_nettype wire

### rtl/format_sector_id_interleaver_core.sv
// top level of the format sector id interleaver
// Push a track number and the block returns the sector ID entries for formatting that
// track, head 0 first, with a 1:2 interleave plus head and track skew; a geometry other
// than 18 or 21 sectors per track gives one error entry instead. The back-end sequencer
// produces one entry per cycle while the result register is empty or being popped, and
// loads the next track only after the last entry of the current one. A track passes
// through the command queue and the sequencer's command register before its first entry
// reaches the result register, and the front end queues up to two further tracks
// meanwhile. Write configuration only while idle.
`default_nettype none
module format_sector_id_interleaver_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  wire  [fsi_pkg::TRACK_WIDTH-1:0]      req_track_number,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output logic [fsi_pkg::TRACK_WIDTH-1:0]      rsp_id_track,
   output logic                                 rsp_id_head,
   output logic [fsi_pkg::SECTOR_WIDTH-1:0]     rsp_id_sector,
   output logic [fsi_pkg::SIZE_WIDTH-1:0]       rsp_id_size_code,
   output logic                                 rsp_last_entry,
   output logic                                 rsp_bad_geometry,
   input  wire                                  csr_write_enable,
   input  wire                                  csr_index,
   input  wire  [fsi_pkg::CSR_WIDTH-1:0]        csr_write_data
);

   fsi_pkg::cmd_link_type cmd_link;
   logic                  cmd_take;

   fsi_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_track_number (req_track_number),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd_link         (cmd_link),
      .cmd_take         (cmd_take)
   );

   fsi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_link         (cmd_link),
      .cmd_take         (cmd_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_id_track     (rsp_id_track),
      .rsp_id_head      (rsp_id_head),
      .rsp_id_sector    (rsp_id_sector),
      .rsp_id_size_code (rsp_id_size_code),
      .rsp_last_entry   (rsp_last_entry),
      .rsp_bad_geometry (rsp_bad_geometry)
   );

endmodule
`default_nettype wire
